// File: rtl/core/jbt_pkg.sv
// Shared types, character codes and keyword tables for the JSON byte tokenizer.
// No dependencies; imported by jbt_lexer, jbt_out_buf and json_byte_tokenizer.
package jbt_pkg;

  // Token kinds carried on the output tuser
  localparam logic [2:0] KIND_PUNCT  = 3'd0;
  localparam logic [2:0] KIND_NUMBER = 3'd1;
  localparam logic [2:0] KIND_STRING = 3'd2;
  localparam logic [2:0] KIND_BOOL   = 3'd3;
  localparam logic [2:0] KIND_NULL   = 3'd4;
  localparam logic [2:0] KIND_END    = 3'd5;
  localparam logic [2:0] KIND_ERROR  = 3'd6;

  // Input item kinds
  localparam logic MODE_TEXT = 1'b0;
  localparam logic MODE_END  = 1'b1;

  // Keyword selectors
  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  // Character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_T   = 8'h74;

  typedef enum logic [3:0] {
    LX_IDLE, LX_ERROR, LX_STR, LX_STR_ESC, LX_KEYWORD,
    LX_NUM_SIGN, LX_NUM_ZERO, LX_NUM_INT, LX_NUM_DOT, LX_NUM_FRAC,
    LX_NUM_EXP, LX_NUM_EXP_SIGN, LX_NUM_EXP_DIG
  } lex_state_t;

  // One token result
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       has;
    logic       tok_last;
  } token_t;

  // One result item as held in the output buffer
  typedef struct packed {
    token_t tok;
    logic   run_last;
  } out_item_t;

  // Results of one input item, lexer to output buffer
  typedef struct packed {
    logic [1:0] count;
    out_item_t  item0;
    out_item_t  item1;
  } res_pair_t;

  function automatic token_t mk_tok(logic [2:0] kind, logic [7:0] data,
                                    logic has, logic tok_last);
    token_t t;
    t.kind     = kind;
    t.data     = has ? data : 8'h00;
    t.has      = has;
    t.tok_last = tok_last;
    return t;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Keyword text: true, false, null
  function automatic logic [7:0] kw_char(logic [1:0] sel, logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (sel)
      KW_TRUE: begin
        case (pos)
          3'd0: ch = 8'h74;
          3'd1: ch = 8'h72;
          3'd2: ch = 8'h75;
          3'd3: ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
      KW_FALSE: begin
        case (pos)
          3'd0: ch = 8'h66;
          3'd1: ch = 8'h61;
          3'd2: ch = 8'h6C;
          3'd3: ch = 8'h73;
          3'd4: ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          3'd0: ch = 8'h6E;
          3'd1: ch = 8'h75;
          3'd2: ch = 8'h6C;
          3'd3: ch = 8'h6C;
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] kw_len(logic [1:0] sel);
    return (sel == KW_FALSE) ? 3'd5 : 3'd4;
  endfunction

endpackage

// File: rtl/core/jbt_lexer.sv
// Lexer state register and per-byte transition logic.
// Depends on jbt_pkg; produces up to two token results per accepted item.
module jbt_lexer
  import jbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       mode,
  input  logic [7:0] text_byte,
  output res_pair_t  results
);

  lex_state_t lex_state, lex_state_next;
  logic [1:0] kw_sel, kw_sel_next;
  logic [2:0] kw_pos, kw_pos_next;

  // Token start decode, shared by idle and by a byte that closes a number
  typedef struct packed {
    logic       emit;
    token_t     tok;
    lex_state_t st;
    logic       kw;
    logic [1:0] ksel;
  } start_t;

  function automatic start_t start_lex(logic [7:0] c);
    start_t s;
    s.emit = 1'b0;
    s.tok  = '0;
    s.st   = LX_IDLE;
    s.kw   = 1'b0;
    s.ksel = KW_TRUE;
    if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_FF) begin
      s.emit = 1'b0;
    end else if (c == CH_LBRACE || c == CH_RBRACE || c == CH_LBRACK ||
                 c == CH_RBRACK || c == CH_COLON || c == CH_COMMA) begin
      s.emit = 1'b1;
      s.tok  = mk_tok(KIND_PUNCT, c, 1'b1, 1'b1);
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      s.emit = 1'b1;
      s.tok  = mk_tok(KIND_NUMBER, c, 1'b1, 1'b0);
      s.st   = LX_NUM_SIGN;
    end else if (c == CH_ZERO) begin
      s.emit = 1'b1;
      s.tok  = mk_tok(KIND_NUMBER, c, 1'b1, 1'b0);
      s.st   = LX_NUM_ZERO;
    end else if (is_digit(c)) begin
      s.emit = 1'b1;
      s.tok  = mk_tok(KIND_NUMBER, c, 1'b1, 1'b0);
      s.st   = LX_NUM_INT;
    end else if (c == CH_QUOTE) begin
      s.st   = LX_STR;
    end else if (c == CH_LO_T || c == CH_LO_F || c == CH_LO_N) begin
      s.kw   = 1'b1;
      s.ksel = (c == CH_LO_T) ? KW_TRUE : (c == CH_LO_F) ? KW_FALSE : KW_NULL;
      s.emit = 1'b1;
      s.tok  = mk_tok((c == CH_LO_N) ? KIND_NULL : KIND_BOOL, c, 1'b1, 1'b0);
      s.st   = LX_KEYWORD;
    end else begin
      s.emit = 1'b1;
      s.tok  = mk_tok(KIND_ERROR, c, 1'b1, 1'b1);
      s.st   = LX_ERROR;
    end
    return s;
  endfunction

  start_t     start_s;
  logic       emit0, emit1;
  token_t     r0, r1;
  logic [1:0] sel_eff;
  logic [2:0] pos_inc;
  logic [2:0] kind_kw;
  logic [7:0] esc_byte;
  logic       esc_ok;

  assign start_s = start_lex(text_byte);
  assign sel_eff = (kw_sel == 2'd3) ? KW_NULL : kw_sel;
  assign pos_inc = kw_pos + 3'd1;
  assign kind_kw = (sel_eff == KW_NULL) ? KIND_NULL : KIND_BOOL;

  // Escape decode
  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = text_byte;
    if (text_byte == CH_QUOTE || text_byte == CH_BSLASH || text_byte == CH_SLASH) begin
      esc_byte = text_byte;
    end else if (text_byte == CH_LO_B) begin
      esc_byte = CH_BS;
    end else if (text_byte == CH_LO_F) begin
      esc_byte = CH_FF;
    end else if (text_byte == CH_LO_N) begin
      esc_byte = CH_LF;
    end else if (text_byte == CH_LO_R) begin
      esc_byte = CH_CR;
    end else if (text_byte == CH_LO_T) begin
      esc_byte = CH_TAB;
    end else begin
      esc_ok = 1'b0;
    end
  end

  // Next state and results
  always_comb begin
    lex_state_next = lex_state;
    kw_sel_next    = kw_sel;
    kw_pos_next    = kw_pos;
    emit0          = 1'b0;
    emit1          = 1'b0;
    r0             = '0;
    r1             = '0;
    if (mode == MODE_END) begin
      // End of text: close or flag the pending token, then the end marker
      unique case (lex_state) inside
        LX_IDLE, LX_ERROR: begin
          emit0 = 1'b1;
          r0    = mk_tok(KIND_END, 8'h00, 1'b0, 1'b1);
        end
        LX_NUM_ZERO, LX_NUM_INT, LX_NUM_FRAC, LX_NUM_EXP_DIG: begin
          emit0 = 1'b1;
          r0    = mk_tok(KIND_NUMBER, 8'h00, 1'b0, 1'b1);
          emit1 = 1'b1;
          r1    = mk_tok(KIND_END, 8'h00, 1'b0, 1'b1);
        end
        default: begin
          emit0 = 1'b1;
          r0    = mk_tok(KIND_ERROR, 8'h00, 1'b0, 1'b1);
          emit1 = 1'b1;
          r1    = mk_tok(KIND_END, 8'h00, 1'b0, 1'b1);
        end
      endcase
      lex_state_next = LX_IDLE;
      kw_sel_next    = KW_TRUE;
      kw_pos_next    = 3'd0;
    end else begin
      unique case (lex_state) inside
        LX_ERROR: begin
          lex_state_next = LX_ERROR;
        end
        LX_STR: begin
          if (text_byte == CH_QUOTE) begin
            emit0          = 1'b1;
            r0             = mk_tok(KIND_STRING, 8'h00, 1'b0, 1'b1);
            lex_state_next = LX_IDLE;
          end else if (text_byte == CH_BSLASH) begin
            lex_state_next = LX_STR_ESC;
          end else begin
            emit0 = 1'b1;
            r0    = mk_tok(KIND_STRING, text_byte, 1'b1, 1'b0);
          end
        end
        LX_STR_ESC: begin
          emit0 = 1'b1;
          if (esc_ok) begin
            r0             = mk_tok(KIND_STRING, esc_byte, 1'b1, 1'b0);
            lex_state_next = LX_STR;
          end else begin
            r0             = mk_tok(KIND_ERROR, text_byte, 1'b1, 1'b1);
            lex_state_next = LX_ERROR;
          end
        end
        LX_KEYWORD: begin
          emit0 = 1'b1;
          if (kw_pos < kw_len(sel_eff) && text_byte == kw_char(sel_eff, kw_pos)) begin
            if (pos_inc == kw_len(sel_eff)) begin
              r0             = mk_tok(kind_kw, text_byte, 1'b1, 1'b1);
              lex_state_next = LX_IDLE;
              kw_pos_next    = 3'd0;
            end else begin
              r0          = mk_tok(kind_kw, text_byte, 1'b1, 1'b0);
              kw_pos_next = pos_inc;
            end
          end else begin
            r0             = mk_tok(KIND_ERROR, text_byte, 1'b1, 1'b1);
            lex_state_next = LX_ERROR;
          end
        end
        LX_NUM_SIGN, LX_NUM_DOT, LX_NUM_EXP_SIGN: begin
          // A digit is required here
          emit0 = 1'b1;
          if (is_digit(text_byte)) begin
            r0 = mk_tok(KIND_NUMBER, text_byte, 1'b1, 1'b0);
            if (lex_state == LX_NUM_SIGN) begin
              lex_state_next = (text_byte == CH_ZERO) ? LX_NUM_ZERO : LX_NUM_INT;
            end else if (lex_state == LX_NUM_DOT) begin
              lex_state_next = LX_NUM_FRAC;
            end else begin
              lex_state_next = LX_NUM_EXP_DIG;
            end
          end else begin
            r0             = mk_tok(KIND_ERROR, text_byte, 1'b1, 1'b1);
            lex_state_next = LX_ERROR;
          end
        end
        LX_NUM_EXP: begin
          emit0 = 1'b1;
          if (text_byte == CH_PLUS || text_byte == CH_MINUS) begin
            r0             = mk_tok(KIND_NUMBER, text_byte, 1'b1, 1'b0);
            lex_state_next = LX_NUM_EXP_SIGN;
          end else if (is_digit(text_byte)) begin
            r0             = mk_tok(KIND_NUMBER, text_byte, 1'b1, 1'b0);
            lex_state_next = LX_NUM_EXP_DIG;
          end else begin
            r0             = mk_tok(KIND_ERROR, text_byte, 1'b1, 1'b1);
            lex_state_next = LX_ERROR;
          end
        end
        LX_NUM_ZERO, LX_NUM_INT, LX_NUM_FRAC, LX_NUM_EXP_DIG: begin
          emit0 = 1'b1;
          if (is_digit(text_byte) && lex_state != LX_NUM_ZERO) begin
            r0 = mk_tok(KIND_NUMBER, text_byte, 1'b1, 1'b0);
          end else if (text_byte == CH_DOT && lex_state != LX_NUM_FRAC &&
                       lex_state != LX_NUM_EXP_DIG) begin
            r0             = mk_tok(KIND_NUMBER, text_byte, 1'b1, 1'b0);
            lex_state_next = LX_NUM_DOT;
          end else if ((text_byte == CH_LO_E || text_byte == CH_UP_E) &&
                       lex_state != LX_NUM_EXP_DIG) begin
            r0             = mk_tok(KIND_NUMBER, text_byte, 1'b1, 1'b0);
            lex_state_next = LX_NUM_EXP;
          end else begin
            // Close the number, then lex this byte afresh
            r0             = mk_tok(KIND_NUMBER, 8'h00, 1'b0, 1'b1);
            emit1          = start_s.emit;
            r1             = start_s.tok;
            lex_state_next = start_s.st;
            if (start_s.kw) begin
              kw_sel_next = start_s.ksel;
              kw_pos_next = 3'd1;
            end
          end
        end
        default: begin
          emit0          = start_s.emit;
          r0             = start_s.tok;
          lex_state_next = start_s.st;
          if (start_s.kw) begin
            kw_sel_next = start_s.ksel;
            kw_pos_next = 3'd1;
          end
        end
      endcase
    end
  end

  // Pack results; emit1 only ever follows emit0
  always_comb begin
    results.count          = emit0 ? (emit1 ? 2'd2 : 2'd1) : 2'd0;
    results.item0.tok      = r0;
    results.item0.run_last = !emit1;
    results.item1.tok      = r1;
    results.item1.run_last = 1'b1;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state <= LX_IDLE;
      kw_sel    <= KW_TRUE;
      kw_pos    <= 3'd0;
    end else if (accept) begin
      lex_state <= lex_state_next;
      kw_sel    <= kw_sel_next;
      kw_pos    <= kw_pos_next;
    end
  end

endmodule

// File: rtl/core/jbt_out_buf.sv
// Two-entry result register between the lexer and the output stream.
// Depends on jbt_pkg; frees itself in the cycle its last entry is taken.
module jbt_out_buf
  import jbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  res_pair_t results,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic [1:0] count;
  out_item_t  slot0, slot1;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign out_item  = slot0;
  // Room for a new item's results once the last held one leaves
  assign free      = (count == 2'd0) || (count == 2'd1 && out_ready);

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= results.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  // Payload slots
  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= results.item0;
      slot1 <= results.item1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

// File: rtl/core/json_byte_tokenizer.sv
// Top level of the streaming JSON byte tokenizer.
// Depends on jbt_pkg, jbt_lexer and jbt_out_buf.
//
//  channel  | dir | tdata                            | tuser                    | tlast
//  s_axis   | in  | [7:0] text_byte                  | [0] mode                 | -
//  m_axis   | out | [7:0] data_byte, [8] token_last  | [2:0] token_kind, [3] has_byte | run_last
//
// One text byte per cycle while the output register has room: the lexer state updates in the
// accept cycle and results land in a two-entry output register the next cycle.
// An item that gives two results (a number closed by another token's byte, end of text
// inside a token) holds off s_axis until the first of the two results is taken.
// s_axis_tready depends on m_axis_tready when one result is held.
// Synchronous reset returns the lexer to idle and empties the output register.
module json_byte_tokenizer
  import jbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic [0:0]  s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [8] token_last, rest zero
  output logic [3:0]  m_axis_tuser,   // [2:0] token_kind, [3] has_byte
  output logic        m_axis_tlast    // run_last
);

  logic      accept;
  logic      buf_free;
  res_pair_t results;
  out_item_t item;

  assign s_axis_tready = buf_free;
  assign accept        = s_axis_tvalid && buf_free;

  jbt_lexer u_lexer (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .mode      (s_axis_tuser[0]),
    .text_byte (s_axis_tdata),
    .results   (results)
  );

  jbt_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .results   (results),
    .free      (buf_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (item)
  );

  // Output packing
  assign m_axis_tdata = {7'b0, item.tok.tok_last, item.tok.data};
  assign m_axis_tuser = {item.tok.has, item.tok.kind};
  assign m_axis_tlast = item.run_last;

endmodule

// File: tb/tb_json_byte_tokenizer.sv
// Self-checking testbench for json_byte_tokenizer: streams JSON text bytes in,
// predicts the token items in its own lexer and compares every output item.
// Depends on jbt_pkg and the json_byte_tokenizer RTL.
module tb_json_byte_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  import jbt_pkg::*;

  // One input item: text byte or end of text
  typedef struct packed {
    logic       mode;
    logic [7:0] text;
  } text_item_t;

  // One expected output item
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       has;
    logic       tok_last;
    logic       run_last;
  } token_res_t;

  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned TEXT_ITEMS   = 1530;
  localparam int unsigned HOLD_AFTER   = 400;
  localparam int unsigned HOLD_CYCLES  = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic [0:0]  s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;

  text_item_t item_q[$];
  token_res_t token_q[$];
  token_res_t step_q[$];

  // Predictor state
  lex_state_t  lx     = LX_IDLE;
  logic [1:0]  kw_sel = KW_TRUE;
  logic [2:0]  kw_pos = 3'd0;

  int unsigned fail_cnt    = 0;
  int unsigned checked_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap    = 0;
  int unsigned send_calm   = 0;
  int unsigned rdy_off     = 0;
  int unsigned rcv_calm    = 0;
  int unsigned hold_cnt    = 0;
  bit          hold_done   = 1'b0;

  json_byte_tokenizer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------
  task automatic emit(logic [2:0] kind, logic [7:0] data, logic has, logic last);
    token_res_t r;
    r.kind     = kind;
    r.data     = has ? data : 8'h00;
    r.has      = has;
    r.tok_last = last;
    r.run_last = 1'b0;
    step_q = {step_q, r};
  endtask

  task automatic lex_fail(logic [7:0] c);
    emit(KIND_ERROR, c, 1'b1, 1'b1);
    lx = LX_ERROR;
  endtask

  function automatic bit is_num_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Lex a byte from the idle state
  task automatic lex_start(logic [7:0] c);
    if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_FF) begin
      // whitespace: nothing out
    end else if (c == CH_LBRACE || c == CH_RBRACE || c == CH_LBRACK || c == CH_RBRACK ||
                 c == CH_COLON || c == CH_COMMA) begin
      emit(KIND_PUNCT, c, 1'b1, 1'b1);
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      emit(KIND_NUMBER, c, 1'b1, 1'b0);
      lx = LX_NUM_SIGN;
    end else if (c == CH_ZERO) begin
      emit(KIND_NUMBER, c, 1'b1, 1'b0);
      lx = LX_NUM_ZERO;
    end else if (is_num_digit(c)) begin
      emit(KIND_NUMBER, c, 1'b1, 1'b0);
      lx = LX_NUM_INT;
    end else if (c == CH_QUOTE) begin
      lx = LX_STR;
    end else if (c == CH_LO_T || c == CH_LO_F || c == CH_LO_N) begin
      kw_sel = (c == CH_LO_T) ? KW_TRUE : (c == CH_LO_F) ? KW_FALSE : KW_NULL;
      kw_pos = 3'd1;
      emit((kw_sel == KW_NULL) ? KIND_NULL : KIND_BOOL, c, 1'b1, 1'b0);
      lx = LX_KEYWORD;
    end else begin
      lex_fail(c);
    end
  endtask

  // A complete number ends: end marker, then the byte is lexed afresh
  task automatic lex_close_number(logic [7:0] c);
    emit(KIND_NUMBER, 8'h00, 1'b0, 1'b1);
    lx = LX_IDLE;
    lex_start(c);
  endtask

  task automatic lex_text(logic [7:0] c);
    logic [7:0] d;
    bit         esc_ok;
    string      word;
    logic [2:0] kind;
    case (lx)
      LX_ERROR: begin
      end
      LX_STR: begin
        if (c == CH_QUOTE) begin
          emit(KIND_STRING, 8'h00, 1'b0, 1'b1);
          lx = LX_IDLE;
        end else if (c == CH_BSLASH) begin
          lx = LX_STR_ESC;
        end else begin
          emit(KIND_STRING, c, 1'b1, 1'b0);
        end
      end
      LX_STR_ESC: begin
        esc_ok = 1'b1;
        d = c;
        case (c)
          CH_QUOTE, CH_BSLASH, CH_SLASH: d = c;
          CH_LO_B: d = CH_BS;
          CH_LO_F: d = CH_FF;
          CH_LO_N: d = CH_LF;
          CH_LO_R: d = CH_CR;
          CH_LO_T: d = CH_TAB;
          default: esc_ok = 1'b0;
        endcase
        if (esc_ok) begin
          emit(KIND_STRING, d, 1'b1, 1'b0);
          lx = LX_STR;
        end else begin
          lex_fail(c);
        end
      end
      LX_KEYWORD: begin
        case (kw_sel)
          KW_TRUE:  word = "true";
          KW_FALSE: word = "false";
          default:  word = "null";
        endcase
        kind = (kw_sel == KW_TRUE || kw_sel == KW_FALSE) ? KIND_BOOL : KIND_NULL;
        if (kw_pos < word.len() && c == word[kw_pos]) begin
          kw_pos = kw_pos + 3'd1;
          if (kw_pos == word.len()) begin
            emit(kind, c, 1'b1, 1'b1);
            lx = LX_IDLE;
            kw_pos = 3'd0;
          end else begin
            emit(kind, c, 1'b1, 1'b0);
          end
        end else begin
          lex_fail(c);
        end
      end
      LX_NUM_SIGN: begin
        if (c == CH_ZERO) begin
          emit(KIND_NUMBER, c, 1'b1, 1'b0);
          lx = LX_NUM_ZERO;
        end else if (is_num_digit(c)) begin
          emit(KIND_NUMBER, c, 1'b1, 1'b0);
          lx = LX_NUM_INT;
        end else begin
          lex_fail(c);
        end
      end
      LX_NUM_ZERO, LX_NUM_INT, LX_NUM_FRAC: begin
        if (is_num_digit(c) && lx != LX_NUM_ZERO) begin
          emit(KIND_NUMBER, c, 1'b1, 1'b0);
        end else if (c == CH_DOT && lx != LX_NUM_FRAC) begin
          emit(KIND_NUMBER, c, 1'b1, 1'b0);
          lx = LX_NUM_DOT;
        end else if (c == CH_LO_E || c == CH_UP_E) begin
          emit(KIND_NUMBER, c, 1'b1, 1'b0);
          lx = LX_NUM_EXP;
        end else begin
          lex_close_number(c);
        end
      end
      LX_NUM_DOT: begin
        if (is_num_digit(c)) begin
          emit(KIND_NUMBER, c, 1'b1, 1'b0);
          lx = LX_NUM_FRAC;
        end else begin
          lex_fail(c);
        end
      end
      LX_NUM_EXP: begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          emit(KIND_NUMBER, c, 1'b1, 1'b0);
          lx = LX_NUM_EXP_SIGN;
        end else if (is_num_digit(c)) begin
          emit(KIND_NUMBER, c, 1'b1, 1'b0);
          lx = LX_NUM_EXP_DIG;
        end else begin
          lex_fail(c);
        end
      end
      LX_NUM_EXP_SIGN: begin
        if (is_num_digit(c)) begin
          emit(KIND_NUMBER, c, 1'b1, 1'b0);
          lx = LX_NUM_EXP_DIG;
        end else begin
          lex_fail(c);
        end
      end
      LX_NUM_EXP_DIG: begin
        if (is_num_digit(c)) begin
          emit(KIND_NUMBER, c, 1'b1, 1'b0);
        end else begin
          lex_close_number(c);
        end
      end
      default: begin
        lx = LX_IDLE;
        lex_start(c);
      end
    endcase
  endtask

  // End of text: close a complete number, flag an unfinished token, then the end marker
  task automatic lex_end();
    case (lx)
      LX_IDLE, LX_ERROR: begin
      end
      LX_NUM_ZERO, LX_NUM_INT, LX_NUM_FRAC, LX_NUM_EXP_DIG: begin
        emit(KIND_NUMBER, 8'h00, 1'b0, 1'b1);
      end
      default: begin
        emit(KIND_ERROR, 8'h00, 1'b0, 1'b1);
      end
    endcase
    emit(KIND_END, 8'h00, 1'b0, 1'b1);
    lx = LX_IDLE;
    kw_sel = KW_TRUE;
    kw_pos = 3'd0;
  endtask

  // Predict the tokens of one accepted item and queue them
  task automatic tokenize(text_item_t it);
    token_res_t r;
    step_q.delete();
    if (it.mode == MODE_END) lex_end();
    else lex_text(it.text);
    foreach (step_q[i]) begin
      r = step_q[i];
      r.run_last = (i == step_q.size() - 1);
      token_q = {token_q, r};
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------
  task automatic push_text(logic [7:0] c);
    text_item_t it;
    it.mode = MODE_TEXT;
    it.text = c;
    item_q = {item_q, it};
  endtask

  task automatic push_end();
    text_item_t it;
    it.mode = MODE_END;
    it.text = 8'($urandom_range(0, 255));
    item_q = {item_q, it};
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) push_text(s[i]);
  endtask

  task automatic push_digit();
    push_text(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic push_number();
    if ($urandom_range(0, 2) == 0) push_text($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
    if ($urandom_range(0, 2) == 0) begin
      push_text(CH_ZERO);
    end else begin
      push_text(CH_ZERO + 8'($urandom_range(1, 9)));
      repeat ($urandom_range(0, 3)) push_digit();
    end
    if ($urandom_range(0, 1)) begin
      push_text(CH_DOT);
      repeat ($urandom_range(1, 3)) push_digit();
    end
    if ($urandom_range(0, 2) == 0) begin
      push_text($urandom_range(0, 1) ? CH_LO_E : CH_UP_E);
      if ($urandom_range(0, 1)) push_text($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      repeat ($urandom_range(1, 2)) push_digit();
    end
  endtask

  // String body byte: anything but quote and backslash, or a valid escape
  task automatic push_string_body();
    logic [7:0] c;
    if ($urandom_range(0, 4) == 0) begin
      push_text(CH_BSLASH);
      case ($urandom_range(0, 7))
        0: push_text(CH_QUOTE);
        1: push_text(CH_BSLASH);
        2: push_text(CH_SLASH);
        3: push_text(CH_LO_B);
        4: push_text(CH_LO_F);
        5: push_text(CH_LO_N);
        6: push_text(CH_LO_R);
        default: push_text(CH_LO_T);
      endcase
    end else begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
      push_text(c);
    end
  endtask

  task automatic push_keyword_word(int sel, int upto);
    string word;
    case (sel)
      0: word = "true";
      1: word = "false";
      default: word = "null";
    endcase
    if (upto <= 0 || upto > word.len()) upto = word.len();
    for (int i = 0; i < upto; i++) push_text(word[i]);
  endtask

  // Malformed input: bad bytes, broken keywords, escapes and numbers,
  // and text that ends inside a token
  task automatic push_broken();
    case ($urandom_range(0, 4))
      0: push_text(8'($urandom_range(0, 255)));
      1: begin
        push_keyword_word($urandom_range(0, 2), $urandom_range(1, 3));
        if ($urandom_range(0, 1)) push_text(8'($urandom_range(0, 255)));
        else push_end();
      end
      2: begin
        push_text(CH_QUOTE);
        push_text(CH_BSLASH);
        push_text(8'($urandom_range(0, 255)));
      end
      3: begin
        case ($urandom_range(0, 2))
          0: push_text(CH_MINUS);
          1: push_str("1.");
          default: push_str("1e");
        endcase
        if ($urandom_range(0, 1)) push_end();
        else push_text(8'($urandom_range(0, 255)));
      end
      default: begin
        push_text(CH_QUOTE);
        repeat ($urandom_range(0, 3)) push_string_body();
        if ($urandom_range(0, 1)) push_text(CH_BSLASH);
        push_end();
      end
    endcase
  endtask

  task automatic push_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 4))
          0: push_text(CH_SPACE);
          1: push_text(CH_TAB);
          2: push_text(CH_LF);
          3: push_text(CH_CR);
          default: push_text(CH_FF);
        endcase
      end
    end else if (r < 35) begin
      case ($urandom_range(0, 5))
        0: push_text(CH_LBRACE);
        1: push_text(CH_RBRACE);
        2: push_text(CH_LBRACK);
        3: push_text(CH_RBRACK);
        4: push_text(CH_COLON);
        default: push_text(CH_COMMA);
      endcase
    end else if (r < 55) begin
      push_number();
    end else if (r < 75) begin
      push_text(CH_QUOTE);
      repeat ($urandom_range(0, 6)) push_string_body();
      push_text(CH_QUOTE);
    end else if (r < 90) begin
      push_keyword_word($urandom_range(0, 2), 0);
    end else begin
      push_broken();
    end
  endtask

  // Gap length: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // ---------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : driver
    bit holding;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      holding = s_tvalid && !s_tready;
      if (s_tvalid && s_tready) begin
        tokenize(item_q[0]);
        item_q.pop_front();
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else if ($urandom_range(0, 99) < 3) begin
          send_calm = $urandom_range(30, 120);
          send_gap = 0;
        end else begin
          send_gap = $urandom_range(0, 1) ? pick_gap() : 0;
        end
      end
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (item_q.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= item_q[0].text;
          s_tuser  <= item_q[0].mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output monitor and checker
  // ---------------------------------------------------------------------
  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : monitor
    token_res_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (token_q.size() == 0) begin
          $display("%0t ns: unexpected item, actual kind %0h data %0h", $time,
                   m_tuser[2:0], m_tdata[7:0]);
          fail_cnt++;
        end else begin
          want = token_q.pop_front();
          check_field("token_kind", 8'(want.kind), 8'(m_tuser[2:0]));
          check_field("data_byte", want.data, m_tdata[7:0]);
          check_field("has_byte", 8'(want.has), 8'(m_tuser[3]));
          check_field("token_last", 8'(want.tok_last), 8'(m_tdata[8]));
          check_field("run_last", 8'(want.run_last), 8'(m_tlast));
          check_field("tdata pad", 8'h00, 8'(m_tdata[15:9]));
        end
        checked_cnt++;
      end
      // Ready pattern: random stalls, plus one long hold-off after HOLD_AFTER items to back the block up
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else if (!hold_done && checked_cnt >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_cnt = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (rdy_off > 0) begin
        rdy_off--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (rcv_calm > 0) rcv_calm--;
        else if ($urandom_range(0, 99) < 3) rcv_calm = $urandom_range(30, 120);
        else if ($urandom_range(0, 3) == 0) rdy_off = pick_gap();
      end
    end
  end

  // Watchdog: too long without any handshake
  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("json_byte_tokenizer regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    // Directed: bad bytes at both extremes, error recovery, end of text after an error,
    // when idle, after a number and after a bare sign, number close, escapes and a keyword
    push_text(8'h00);
    push_str("x");
    push_end();
    push_end();
    push_str("-0.5e+7,");
    push_str("\"a\\n\"");
    push_str("true");
    push_text(8'hFF);
    push_end();
    push_str("12");
    push_end();
    push_str("+");
    push_end();

    // Random documents, each closed by end of text
    while (item_q.size() < TEXT_ITEMS) begin
      repeat ($urandom_range(1, 12)) push_token();
      push_end();
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (item_q.size() != 0 || token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("json_byte_tokenizer regression: pass");
    end else begin
      $display("json_byte_tokenizer regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/jbt_pkg.sv
rtl/core/jbt_lexer.sv
rtl/core/jbt_out_buf.sv
rtl/core/json_byte_tokenizer.sv
tb/tb_json_byte_tokenizer.sv
